FILE: rtl/hvp_pkg.sv
`timescale 1ns / 1ps

package hvp_pkg;

  // Window geometry.
  localparam int RADIUS     = 20;
  localparam int SCAN_SHIFT = 7;
  localparam int WIN        = 2 * RADIUS + 1;
  localparam int CELLS      = WIN * WIN;
  localparam int ADDR_W     = $clog2(CELLS);
  localparam int CW         = $clog2(WIN);
  localparam int RW         = $clog2(RADIUS);
  localparam int KW         = $clog2(2 * RADIUS - 1);
  localparam int CENTER     = RADIUS * WIN + RADIUS;

  // Distance cost table over one quadrant, indexed by |dx| * (RADIUS+1) + |dy|.
  localparam int COST_N = (RADIUS + 1) * (RADIUS + 1);
  localparam int CI_W   = $clog2(COST_N);
  localparam int CST_W  = SCAN_SHIFT + 2;

  // Request codes.
  localparam logic [1:0] REQ_LOAD = 2'd0;
  localparam logic [1:0] REQ_RUN  = 2'd1;
  localparam logic [1:0] REQ_READ = 2'd2;

  typedef logic [CST_W-1:0] cost_tab_t [COST_N];

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic              clr_vis;
    logic              clr_val;
    logic [ADDR_W-1:0] clr_addr;
    logic              load;
    logic              read_item;
    logic              run_accept;
    logic              center_rd;
    logic              seed;
    logic              visit_rd;
    logic              visit_wr;
    logic              finish;
    logic [CW-1:0]     x;
    logic [CW-1:0]     y;
    logic [RW-1:0]     ring;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic visible;
  } stat_t;

  function automatic longint isqrt(longint n);
    longint rem;
    longint root;
    longint b;
    rem  = n;
    root = 0;
    b    = longint'(1) << 62;
    for (int s = 0; s < 32; s++) begin
      if (b != 0) begin
        if (rem >= root + b) begin
          rem  = rem - (root + b);
          root = (root >> 1) + b;
        end else begin
          root = root >> 1;
        end
        b = b >> 2;
      end
    end
    return root;
  endfunction

  function automatic cost_tab_t build_cost();
    cost_tab_t t;
    longint    n;
    longint    r;
    longint    q;
    int        m;
    for (int i = 0; i <= RADIUS; i++) begin
      for (int j = 0; j <= RADIUS; j++) begin
        m = (i > j) ? i : j;
        if (m > 0) begin
          n = longint'(i * i + j * j) << (2 * SCAN_SHIFT);
          r = isqrt(n);
          // Quotient of the root by the larger offset, found by counting up.
          q = 0;
          for (int s = 0; s < 512; s++) begin
            if ((q + 1) * longint'(m) <= r) begin
              q = q + 1;
            end
          end
          t[i * (RADIUS + 1) + j] = CST_W'(q);
        end else begin
          t[i * (RADIUS + 1) + j] = '0;
        end
      end
    end
    return t;
  endfunction

  localparam cost_tab_t COST_ROM = build_cost();

endpackage

FILE: rtl/hvp_ctrl.sv
`timescale 1ns / 1ps

module hvp_ctrl
  import hvp_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start_i,
  input  logic [1:0] req_type_i,
  input  stat_t      stat_i,
  output cmd_t       cmd_o,
  output logic       busy_o
);

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_CLEAR,
    ST_CENTER,
    ST_SEED,
    ST_VRD,
    ST_VWR,
    ST_FINISH
  } state_e;

  state_e            state_q;
  logic [ADDR_W-1:0] clr_q;
  logic [RW-1:0]     ring_q;
  logic [KW-1:0]     k_q;
  logic [1:0]        side_q;
  logic              any_q;
  logic              accept;
  logic              any_d;
  int                jo;
  int                xi;
  int                yi;

  assign accept = start_i && (state_q == ST_IDLE);
  assign busy_o = (state_q != ST_IDLE);
  assign any_d  = any_q | stat_i.visible;

  // Cell coordinates for the current ring, position and side.
  always_comb begin
    jo = int'(k_q) - int'(ring_q);
    unique case (side_q)
      2'd0: begin xi = RADIUS + jo;          yi = RADIUS - int'(ring_q); end
      2'd1: begin xi = RADIUS + jo;          yi = RADIUS + int'(ring_q); end
      2'd2: begin xi = RADIUS - int'(ring_q); yi = RADIUS + jo;          end
      default: begin xi = RADIUS + int'(ring_q); yi = RADIUS - jo;       end
    endcase
  end

  // Command decode.
  always_comb begin
    cmd_o            = '0;
    cmd_o.clr_addr   = clr_q;
    cmd_o.x          = CW'(xi);
    cmd_o.y          = CW'(yi);
    cmd_o.ring       = ring_q;
    cmd_o.clr_vis    = (state_q == ST_INIT) || (state_q == ST_CLEAR);
    cmd_o.clr_val    = (state_q == ST_INIT);
    cmd_o.load       = accept && (req_type_i == REQ_LOAD);
    cmd_o.read_item  = accept && (req_type_i == REQ_READ);
    cmd_o.run_accept = accept && (req_type_i == REQ_RUN);
    cmd_o.center_rd  = (state_q == ST_CENTER);
    cmd_o.seed       = (state_q == ST_SEED);
    cmd_o.visit_rd   = (state_q == ST_VRD);
    cmd_o.visit_wr   = (state_q == ST_VWR);
    cmd_o.finish     = (state_q == ST_FINISH);
  end

  // Sequencer: sweeps, center setup and the ring walk.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_INIT;
      clr_q   <= '0;
      ring_q  <= RW'(1);
      k_q     <= '0;
      side_q  <= '0;
      any_q   <= 1'b0;
    end else begin
      unique case (state_q)
        ST_INIT, ST_CLEAR: begin
          if (clr_q == ADDR_W'(CELLS - 1)) begin
            clr_q   <= '0;
            state_q <= (state_q == ST_INIT) ? ST_IDLE : ST_CENTER;
          end else begin
            clr_q <= clr_q + 1'b1;
          end
        end
        ST_IDLE: begin
          if (accept && (req_type_i == REQ_RUN)) begin
            state_q <= ST_CLEAR;
          end
        end
        ST_CENTER: state_q <= ST_SEED;
        ST_SEED: begin
          ring_q  <= RW'(1);
          k_q     <= '0;
          side_q  <= '0;
          any_q   <= 1'b0;
          state_q <= ST_VRD;
        end
        ST_VRD: state_q <= ST_VWR;
        ST_VWR: begin
          if (side_q != 2'd3) begin
            side_q  <= side_q + 1'b1;
            any_q   <= any_d;
            state_q <= ST_VRD;
          end else begin
            side_q <= '0;
            if (int'(k_q) < 2 * int'(ring_q)) begin
              k_q     <= k_q + 1'b1;
              any_q   <= any_d;
              state_q <= ST_VRD;
            end else if (!any_d || (int'(ring_q) == RADIUS - 1)) begin
              any_q   <= any_d;
              state_q <= ST_FINISH;
            end else begin
              ring_q  <= ring_q + 1'b1;
              k_q     <= '0;
              any_q   <= 1'b0;
              state_q <= ST_VRD;
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

FILE: rtl/hvp_datapath.sv
`timescale 1ns / 1ps

module hvp_datapath
  import hvp_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cmd_t        cmd_i,
  input  logic [5:0]  col_i,
  input  logic [5:0]  row_i,
  input  logic [7:0]  height_i,
  input  logic        cell_valid_i,
  input  logic [15:0] scan_range_i,
  output stat_t       stat_o,
  output logic        result_valid_o,
  output logic [15:0] vision_value_o,
  output logic [4:0]  rings_reached_o,
  output logic        run_done_o
);

  logic [7:0]       height_mem [CELLS];
  logic             valid_mem  [CELLS];
  logic [15:0]      vision_mem [CELLS];

  logic              item_inside;
  logic [ADDR_W-1:0] item_addr;
  logic [ADDR_W-1:0] cell_addr;
  logic [ADDR_W-1:0] nb_addr;
  logic [ADDR_W-1:0] h_addr;
  logic [ADDR_W-1:0] vr_addr;
  logic [CI_W-1:0]   cost_idx;

  logic [15:0]       scan_q;
  logic [7:0]        height_q;
  logic [7:0]        horg_q;
  logic              valid_q;
  logic [CST_W-1:0]  cost_q;
  logic [15:0]       vis_rd_q;
  logic [ADDR_W-1:0] addr_q;
  logic [15:0]       v_new;
  logic [15:0]       seed_val;

  logic              res_valid_q;
  logic              run_q;
  logic              inside_q;
  logic [4:0]        rings_q;

  int xo;
  int yo;
  int ai;
  int aj;
  int mx;
  int my;
  int sx;
  int sy;

  // Item addressing.
  assign item_inside = (int'(col_i) < WIN) && (int'(row_i) < WIN);
  assign item_addr   = ADDR_W'(int'(col_i) * WIN + int'(row_i));

  // Visited cell, its inward neighbor and its cost entry.
  always_comb begin
    xo = int'(cmd_i.x) - RADIUS;
    yo = int'(cmd_i.y) - RADIUS;
    ai = (xo < 0) ? -xo : xo;
    aj = (yo < 0) ? -yo : yo;
    if (aj < (ai >> 1)) begin
      mx = 1; my = 0;
    end else if (aj <= 2 * ai) begin
      mx = 1; my = 1;
    end else begin
      mx = 0; my = 1;
    end
    sx = (xo > 0) ? 1 : ((xo < 0) ? -1 : 0);
    if (yo > 0)      sy = 1;
    else if (yo < 0) sy = -1;
    else             sy = -sx;
    cell_addr = ADDR_W'(int'(cmd_i.x) * WIN + int'(cmd_i.y));
    nb_addr   = ADDR_W'((int'(cmd_i.x) - sx * mx) * WIN + (int'(cmd_i.y) - sy * my));
    cost_idx  = CI_W'(ai * (RADIUS + 1) + aj);
  end

  assign h_addr   = cmd_i.center_rd ? ADDR_W'(CENTER) : cell_addr;
  assign vr_addr  = cmd_i.read_item ? item_addr : nb_addr;
  assign seed_val = 16'((32'd1 << (SCAN_SHIFT - 1)) + 32'(scan_q >> (8 - SCAN_SHIFT)));

  // New vision value, wrapped to 16 bits.
  assign v_new = vis_rd_q - {8'd0, height_q} + {8'd0, horg_q} - 16'(cost_q);
  assign stat_o.visible = valid_q && !v_new[15];

  // Height store.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load && item_inside) begin
      height_mem[item_addr] <= height_i;
    end
    height_q <= height_mem[h_addr];
  end

  // Valid store.
  always_ff @(posedge clk_i) begin
    if (cmd_i.clr_val) begin
      valid_mem[cmd_i.clr_addr] <= 1'b0;
    end else if (cmd_i.load && item_inside) begin
      valid_mem[item_addr] <= cell_valid_i;
    end
    valid_q <= valid_mem[cell_addr];
  end

  // Vision store.
  always_ff @(posedge clk_i) begin
    if (cmd_i.clr_vis) begin
      vision_mem[cmd_i.clr_addr] <= '0;
    end else if (cmd_i.seed) begin
      vision_mem[CENTER] <= seed_val;
    end else if (cmd_i.visit_wr && valid_q) begin
      vision_mem[addr_q] <= v_new;
    end
    vis_rd_q <= vision_mem[vr_addr];
  end

  // Cost table read and run operands.
  always_ff @(posedge clk_i) begin
    cost_q <= COST_ROM[cost_idx];
    if (cmd_i.visit_rd) begin
      addr_q <= cell_addr;
    end
    if (cmd_i.run_accept) begin
      scan_q <= scan_range_i;
    end
    if (cmd_i.seed) begin
      horg_q <= height_q;
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= cmd_i.read_item || cmd_i.finish;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.read_item || cmd_i.finish) begin
      run_q    <= cmd_i.finish;
      inside_q <= item_inside;
      rings_q  <= cmd_i.finish ? 5'(cmd_i.ring) : 5'd0;
    end
  end

  assign result_valid_o  = res_valid_q;
  assign vision_value_o  = (!run_q && inside_q) ? vis_rd_q : 16'd0;
  assign rings_reached_o = rings_q;
  assign run_done_o      = run_q;

endmodule

FILE: rtl/heightmap_vision_propagation_top.sv
`timescale 1ns / 1ps

// Channel   Direction  Handshake                     Payload
// request   in         start_i high, busy_o low      req_type_i col_i row_i height_i
//                                                    cell_valid_i scan_range_i
// result    out        result_valid_o, one cycle     vision_value_o rings_reached_o
//                                                    run_done_o
//
// Load and read items leave the block idle; a read answer shows in the cycle after accept.
// A run clears all 1681 entries of the vision store, one entry a cycle, reads the center
// height, seeds the center, then visits each ring cell in a read state and a write state.
// After reset a clearing pass runs over all 1681 entries of the valid and vision stores
// with busy_o high. The receiver cannot stall; each result is shown for exactly one cycle.

module heightmap_vision_propagation_top
  import hvp_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [1:0]  req_type_i,
  input  logic [5:0]  col_i,
  input  logic [5:0]  row_i,
  input  logic [7:0]  height_i,
  input  logic        cell_valid_i,
  input  logic [15:0] scan_range_i,
  output logic        result_valid_o,
  output logic [15:0] vision_value_o,
  output logic [4:0]  rings_reached_o,
  output logic        run_done_o
);

  cmd_t  cmd;
  stat_t stat;

  hvp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .req_type_i (req_type_i),
    .stat_i     (stat),
    .cmd_o      (cmd),
    .busy_o     (busy_o)
  );

  hvp_datapath u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .col_i           (col_i),
    .row_i           (row_i),
    .height_i        (height_i),
    .cell_valid_i    (cell_valid_i),
    .scan_range_i    (scan_range_i),
    .stat_o          (stat),
    .result_valid_o  (result_valid_o),
    .vision_value_o  (vision_value_o),
    .rings_reached_o (rings_reached_o),
    .run_done_o      (run_done_o)
  );

  // A read answer follows an accepted read item.
  a_read_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !run_done_o |->
      $past(start_i && !busy_o && (req_type_i == REQ_READ)))
    else $error("read answer without a read item");

  // A run answer reports at least one ring and no vision value.
  a_run_answer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && run_done_o |-> (rings_reached_o != 5'd0) && (vision_value_o == 16'd0))
    else $error("malformed run answer");

  // A run answer arrives as the block returns to idle.
  a_run_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && run_done_o |-> !busy_o && $past(busy_o))
    else $error("run answer outside run completion");

endmodule

FILE: sim/tb_heightmap_vision_propagation_top.sv
`timescale 1ns / 1ps

module tb_heightmap_vision_propagation_top;
  import hvp_pkg::*;

  localparam logic [1:0] REQ_NONE = 2'd3;
  localparam int MID = 20;
  localparam int SPAN = 41;
  localparam int CYCLE_LIMIT = 3000000;

  typedef struct {
    logic [1:0]  req;
    logic [5:0]  col;
    logic [5:0]  row;
    logic [7:0]  height;
    logic        valid;
    logic [15:0] scan;
  } cell_req_t;

  typedef struct {
    logic [15:0] vision;
    logic [4:0]  rings;
    logic        run;
  } answer_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start_i = 1'b0;
  logic [1:0]  req_type_i = '0;
  logic [5:0]  col_i = '0;
  logic [5:0]  row_i = '0;
  logic [7:0]  height_i = '0;
  logic        cell_valid_i = 1'b0;
  logic [15:0] scan_range_i = '0;
  logic        busy_o;
  logic        result_valid_o;
  logic [15:0] vision_value_o;
  logic [4:0]  rings_reached_o;
  logic        run_done_o;

  heightmap_vision_propagation_top dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .start_i(start_i),
    .busy_o(busy_o),
    .req_type_i(req_type_i),
    .col_i(col_i),
    .row_i(row_i),
    .height_i(height_i),
    .cell_valid_i(cell_valid_i),
    .scan_range_i(scan_range_i),
    .result_valid_o(result_valid_o),
    .vision_value_o(vision_value_o),
    .rings_reached_o(rings_reached_o),
    .run_done_o(run_done_o)
  );

  always #6 clk_i = ~clk_i;

  // Shadow copy of the window state.
  logic [7:0]  terrain [SPAN][SPAN];
  logic        on_map [SPAN][SPAN];
  logic [15:0] sight [SPAN][SPAN];
  logic [15:0] dist_cost [SPAN][SPAN];
  int          step_dx [SPAN][SPAN];
  int          step_dy [SPAN][SPAN];

  cell_req_t pending_reqs[$];
  answer_t   expected_answers[$];
  int        mismatches = 0;
  int        cycles = 0;
  int        gap_left = 0;

  function automatic longint floor_root(longint n);
    longint r;
    r = longint'($sqrt(real'(n)));
    while (r * r > n) r--;
    while ((r + 1) * (r + 1) <= n) r++;
    return r;
  endfunction

  // Build the distance costs and inward steps for all four quadrants, and clear the shadow state.
  function automatic void build_tables();
    int dx;
    int dy;
    int m;
    logic [15:0] c;
    for (int i = 0; i <= MID; i++) begin
      for (int j = 0; j <= MID; j++) begin
        if (j >= i / 2) begin
          dx = (j <= 2 * i) ? -1 : 0;
          dy = -1;
        end else begin
          dx = -1;
          dy = 0;
        end
        step_dx[MID+i][MID+j] = dx;  step_dy[MID+i][MID+j] = dy;
        step_dx[MID-i][MID-j] = -dx; step_dy[MID-i][MID-j] = -dy;
        step_dx[MID+i][MID-j] = dx;  step_dy[MID+i][MID-j] = -dy;
        step_dx[MID-i][MID+j] = -dx; step_dy[MID-i][MID+j] = dy;
        m = (i > j) ? i : j;
        c = (m > 0) ? 16'(floor_root(longint'(i * i + j * j) << 14) / m) : 16'd0;
        dist_cost[MID+i][MID+j] = c;
        dist_cost[MID+i][MID-j] = c;
        dist_cost[MID-i][MID+j] = c;
        dist_cost[MID-i][MID-j] = c;
      end
    end
    dist_cost[MID][MID] = '0;
    for (int x = 0; x < SPAN; x++) begin
      for (int y = 0; y < SPAN; y++) begin
        terrain[x][y] = '0;
        on_map[x][y] = 1'b0;
        sight[x][y] = '0;
      end
    end
  endfunction

  // One cell of the walk; returns 1 when the cell is valid and its new vision is not negative.
  function automatic bit walk_cell(int x, int y, logic [7:0] center_h);
    int nx;
    int ny;
    logic [15:0] prev;
    logic [15:0] v;
    if (!on_map[x][y]) return 1'b0;
    nx = x + step_dx[x][y];
    ny = y + step_dy[x][y];
    prev = (nx >= 0 && nx < SPAN && ny >= 0 && ny < SPAN) ? sight[nx][ny] : 16'd0;
    v = prev - 16'(terrain[x][y]) + 16'(center_h) - dist_cost[x][y];
    sight[x][y] = v;
    return !v[15];
  endfunction

  // Apply one accepted item to the shadow state and queue its answer, for reads and runs.
  function automatic void predict_item(cell_req_t it);
    bit in_window;
    bit any;
    int reached;
    logic [7:0] center_h;
    answer_t a;
    in_window = it.col < SPAN && it.row < SPAN;
    case (it.req)
      REQ_LOAD: begin
        if (in_window) begin
          terrain[it.col][it.row] = it.height;
          on_map[it.col][it.row] = it.valid;
        end
      end
      REQ_RUN: begin
        center_h = terrain[MID][MID];
        reached = 0;
        for (int x = 0; x < SPAN; x++)
          for (int y = 0; y < SPAN; y++) sight[x][y] = '0;
        sight[MID][MID] = 16'(64 + (it.scan >> 1));
        for (int i = 1; i < MID; i++) begin
          any = 1'b0;
          for (int j = -i; j <= i; j++) begin
            if (walk_cell(MID + j, MID - i, center_h)) any = 1'b1;
            if (walk_cell(MID + j, MID + i, center_h)) any = 1'b1;
            if (walk_cell(MID - i, MID + j, center_h)) any = 1'b1;
            if (walk_cell(MID + i, MID - j, center_h)) any = 1'b1;
          end
          reached = i;
          if (!any) break;
        end
        a.vision = '0;
        a.rings = 5'(reached);
        a.run = 1'b1;
        expected_answers.push_back(a);
      end
      REQ_READ: begin
        a.vision = in_window ? sight[it.col][it.row] : 16'd0;
        a.rings = '0;
        a.run = 1'b0;
        expected_answers.push_back(a);
      end
      default: ;
    endcase
  endfunction

  function automatic void add_item(logic [1:0] req, int col, int row, int h, int v, int scan);
    cell_req_t it;
    it.req = req;
    it.col = 6'(col);
    it.row = 6'(row);
    it.height = 8'(h);
    it.valid = 1'(v);
    it.scan = 16'(scan);
    pending_reqs.push_back(it);
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(5, 40);
  endfunction

  // Put the next pending item on the request ports and raise start.
  task automatic drive_next();
    cell_req_t it;
    it = pending_reqs.pop_front();
    req_type_i <= it.req;
    col_i <= it.col;
    row_i <= it.row;
    height_i <= it.height;
    cell_valid_i <= it.valid;
    scan_range_i <= it.scan;
    start_i <= 1'b1;
  endtask

  // Stimulus: a directed opening, then load, run and read phases.
  initial begin
    int k;
    int center_h;
    int n;
    build_tables();
    add_item(REQ_LOAD, MID, MID, 100, 1, 0);
    add_item(REQ_LOAD, 0, 0, 255, 1, 0);
    add_item(REQ_LOAD, 40, 40, 0, 1, 0);
    add_item(REQ_LOAD, 63, 63, 255, 1, 0);
    add_item(REQ_LOAD, 41, 0, 7, 1, 0);
    add_item(REQ_NONE, 63, 63, 255, 1, 65535);
    for (int j = -1; j <= 1; j++) begin
      add_item(REQ_LOAD, MID + j, MID - 1, 100, 1, 0);
      add_item(REQ_LOAD, MID + j, MID + 1, 90, 1, 0);
    end
    add_item(REQ_LOAD, MID - 1, MID, 255, 1, 0);
    add_item(REQ_LOAD, MID + 1, MID, 0, 0, 0);
    add_item(REQ_RUN, 0, 0, 0, 0, 0);
    add_item(REQ_READ, MID, MID, 0, 0, 0);
    add_item(REQ_READ, MID, MID - 1, 0, 0, 0);
    add_item(REQ_RUN, 63, 63, 255, 1, 65535);
    add_item(REQ_READ, MID - 1, MID, 0, 0, 0);
    add_item(REQ_READ, MID + 1, MID, 0, 0, 0);
    add_item(REQ_READ, 63, 63, 0, 0, 0);
    add_item(REQ_READ, 40, 40, 0, 0, 0);
    add_item(REQ_LOAD, MID, MID, 0, 0, 0);
    add_item(REQ_RUN, 0, 0, 0, 0, 30000);
    add_item(REQ_READ, MID + 1, MID + 1, 0, 0, 0);

    center_h = 0;
    n = pending_reqs.size();
    while (n < 1850) begin
      if ($urandom_range(0, 3) == 0) begin
        center_h = $urandom_range(0, 255);
        add_item(REQ_LOAD, MID, MID, center_h, $urandom_range(0, 1), 0);
        n++;
      end
      k = $urandom_range(1, 20);
      repeat ($urandom_range(10, 50)) begin
        if ($urandom_range(0, 19) == 0)
          add_item(REQ_LOAD, $urandom_range(0, 63), $urandom_range(0, 63),
                   $urandom_range(0, 255), $urandom_range(0, 1), $urandom_range(0, 65535));
        else
          add_item(REQ_LOAD, MID + $urandom_range(0, 2 * k) - k,
                   MID + $urandom_range(0, 2 * k) - k,
                   ($urandom_range(0, 4) == 0) ? $urandom_range(0, 255)
                     : (center_h + $urandom_range(0, 16) - 8) & 255,
                   ($urandom_range(0, 6) != 0), $urandom_range(0, 65535));
        n++;
      end
      add_item(REQ_RUN, $urandom_range(0, 63), $urandom_range(0, 63), $urandom_range(0, 255),
               $urandom_range(0, 1),
               ($urandom_range(0, 4) == 0) ? $urandom_range(0, 3000) : $urandom_range(0, 65535));
      n++;
      repeat ($urandom_range(3, 15)) begin
        if ($urandom_range(0, 15) == 0)
          add_item(REQ_NONE, $urandom_range(0, 63), $urandom_range(0, 63), 0, 0, 0);
        else if ($urandom_range(0, 15) == 0)
          add_item(REQ_READ, $urandom_range(0, 63), $urandom_range(0, 63), 0, 0, 0);
        else
          add_item(REQ_READ, MID + $urandom_range(0, 2 * k) - k,
                   MID + $urandom_range(0, 2 * k) - k, 0, 0, 0);
        n++;
      end
    end

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    wait (pending_reqs.size() == 0 && !start_i && expected_answers.size() == 0);
    repeat (50) @(posedge clk_i);
    if (mismatches == 0 && expected_answers.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Driver: predicts each accepted item, then offers the next after a gap.
  always @(posedge clk_i) begin
    cell_req_t it;
    int g;
    if (rst_ni) begin
      if (start_i && !busy_o) begin
        it.req = req_type_i;
        it.col = col_i;
        it.row = row_i;
        it.height = height_i;
        it.valid = cell_valid_i;
        it.scan = scan_range_i;
        predict_item(it);
        g = pick_gap();
        if (g == 0 && pending_reqs.size() > 0) begin
          drive_next();
        end else begin
          start_i <= 1'b0;
          gap_left <= g;
        end
      end else if (!start_i) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
        end else if (pending_reqs.size() > 0) begin
          drive_next();
        end
      end
    end
  end

  // Monitor: compare each answer with the oldest prediction.
  always @(posedge clk_i) begin
    answer_t a;
    if (rst_ni && result_valid_o) begin
      if (expected_answers.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected answer: vision %h rings %0d run %b",
                   vision_value_o, rings_reached_o, run_done_o);
      end else begin
        a = expected_answers.pop_front();
        if (vision_value_o !== a.vision || rings_reached_o !== a.rings ||
            run_done_o !== a.run) begin
          mismatches++;
          if (mismatches <= 10)
            $display("answer mismatch: expected vision %h rings %0d run %b, got %h %0d %b",
                     a.vision, a.rings, a.run, vision_value_o, rings_reached_o, run_done_o);
        end
      end
    end
  end

  // Watchdog on the total cycle count.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

endmodule

FILE: sim.f
rtl/hvp_pkg.sv
rtl/hvp_ctrl.sv
rtl/hvp_datapath.sv
rtl/heightmap_vision_propagation_top.sv
sim/tb_heightmap_vision_propagation_top.sv
